// ----- sv/assert_macros.svh -----
// -----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, compiled out when SYNTH is defined
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// condition must hold whenever the antecedent holds, same edge
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// condition must hold on the edge after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// condition must never be seen
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ----- sv/mtep_pkg.sv -----
// -----------------------------------------------------------------------------
// mtep_pkg
// shared types and constants of the midi track event parser
// -----------------------------------------------------------------------------
package mtep_pkg;

   localparam int unsigned SAMPLE_RATE_HZ_DEF   = 44100;
   localparam int unsigned OSCILLATOR_COUNT_DEF = 4;
   localparam int unsigned QUEUE_DEPTH_DEF      = 4;

   localparam int unsigned MS_PER_TICK_W = 26;
   localparam logic [MS_PER_TICK_W-1:0] MS_PER_TICK_RESET = 26'h001_0000;

   // status bytes and status high nibbles
   localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
   localparam logic [7:0] STATUS_META     = 8'hFF;
   localparam logic [3:0] HI_NOTE_OFF     = 4'h8;
   localparam logic [3:0] HI_NOTE_ON      = 4'h9;
   localparam logic [3:0] HI_PROGRAM      = 4'hC;
   localparam logic [3:0] HI_CHAN_PRESS   = 4'hD;
   localparam logic [3:0] HI_PITCH_BEND   = 4'hE;

   typedef enum logic [1:0] {
      OP_WAIT    = 2'd0,
      OP_KEY_ON  = 2'd1,
      OP_KEY_OFF = 2'd2
   } opcode_type;

   // 2^(s/12) in U1.31, rounded to nearest
   localparam logic [31:0] SEMITONE_Q31 [12] = '{
      32'd2147483648, 32'd2275179671, 32'd2410468894, 32'd2553802834,
      32'd2705659852, 32'd2866546760, 32'd3037000500, 32'd3217589947,
      32'd3408917802, 32'd3611622603, 32'd3826380858, 32'd4053909304
   };

   // one note event handed from the parser to the result sequencer
   typedef struct packed {
      logic        key_on;
      logic [3:0]  channel;
      logic [6:0]  note;
      logic [31:0] time_ms;
   } event_type;

endpackage

// ----- sv/mtep_front.sv -----
// -----------------------------------------------------------------------------
// mtep_front
// byte parser: delta time decode, tick scaling, status classification
// -----------------------------------------------------------------------------
module mtep_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mtep_pkg::MS_PER_TICK_W-1:0]  csr_wr_data,
   input  logic                                byte_valid,
   input  logic [7:0]                          data_byte,
   input  logic                                track_start,
   output logic                                push_valid,
   output mtep_pkg::event_type                 push_event
);

   typedef enum logic [2:0] {
      PH_DELTA,
      PH_STATUS,
      PH_DATA1,
      PH_DATA2,
      PH_LENGTH,
      PH_METATYPE,
      PH_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in, phase_eff;
   logic [31:0] delta_acc_ff, delta_acc_in, acc_eff, acc_shift;
   logic [31:0] skip_ff, skip_in, skip_eff, skip_shift, skip_dec;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  first_ff, first_in;
   logic [mtep_pkg::MS_PER_TICK_W-1:0] ms_per_tick_ff;
   logic        mul_go;
   logic        mul_valid_ff;
   logic [31:0] mul_a_ff;
   logic [57:0] product;
   logic        prod_valid_ff;
   logic [31:0] prod_ff;
   logic [31:0] track_time_ff;
   logic        kill;
   logic [3:0]  byte_hi, status_hi;

   assign byte_hi   = data_byte[7:4];
   assign status_hi = status_ff[7:4];
   assign kill      = byte_valid && track_start;
   assign product   = 58'(mul_a_ff) * 58'(ms_per_tick_ff);

   always_comb begin
      phase_eff    = track_start ? PH_DELTA : phase_ff;
      acc_eff      = track_start ? 32'd0 : delta_acc_ff;
      skip_eff     = track_start ? 32'd0 : skip_ff;
      acc_shift    = {acc_eff[24:0], data_byte[6:0]};
      skip_shift   = {skip_eff[24:0], data_byte[6:0]};
      skip_dec     = skip_ff - 32'd1;
      phase_in     = phase_ff;
      delta_acc_in = delta_acc_ff;
      skip_in      = skip_ff;
      status_in    = status_ff;
      first_in     = first_ff;
      mul_go       = 1'b0;
      push_valid   = 1'b0;
      if (byte_valid) begin
         if (track_start) begin
            phase_in     = PH_DELTA;
            delta_acc_in = 32'd0;
            skip_in      = 32'd0;
         end
         unique case (phase_eff)
            PH_DELTA: begin
               if (!data_byte[7]) begin
                  mul_go       = 1'b1;
                  delta_acc_in = 32'd0;
                  phase_in     = PH_STATUS;
               end else begin
                  delta_acc_in = acc_shift;
                  phase_in     = PH_DELTA;
               end
            end
            PH_STATUS: begin
               status_in = data_byte;
               priority if (data_byte == mtep_pkg::STATUS_SYSEX) begin
                  skip_in  = 32'd0;
                  phase_in = PH_LENGTH;
               end else if (data_byte == mtep_pkg::STATUS_META) begin
                  phase_in = PH_METATYPE;
               end else if (byte_hi >= mtep_pkg::HI_NOTE_OFF &&
                            byte_hi <= mtep_pkg::HI_PITCH_BEND) begin
                  phase_in = PH_DATA1;
               end else begin
                  phase_in = PH_DELTA;
               end
            end
            PH_DATA1: begin
               first_in = data_byte;
               if (status_hi == mtep_pkg::HI_PROGRAM ||
                   status_hi == mtep_pkg::HI_CHAN_PRESS) begin
                  phase_in = PH_DELTA;
               end else begin
                  phase_in = PH_DATA2;
               end
            end
            PH_DATA2: begin
               phase_in   = PH_DELTA;
               push_valid = (status_hi == mtep_pkg::HI_NOTE_OFF) ||
                            (status_hi == mtep_pkg::HI_NOTE_ON);
            end
            PH_METATYPE: begin
               skip_in  = 32'd0;
               phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               skip_in = skip_shift;
               if (!data_byte[7]) begin
                  phase_in = (skip_shift == 32'd0) ? PH_DELTA : PH_SKIP;
               end
            end
            PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) begin
                  phase_in = PH_DELTA;
               end
            end
            default: begin
               phase_in = PH_DELTA;
            end
         endcase
      end
   end

   always_comb begin
      push_event.key_on  = (status_hi == mtep_pkg::HI_NOTE_ON);
      push_event.channel = status_ff[3:0];
      push_event.note    = first_ff[6:0];
      push_event.time_ms = track_time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_DELTA;
         delta_acc_ff   <= '0;
         skip_ff        <= '0;
         status_ff      <= '0;
         first_ff       <= '0;
         ms_per_tick_ff <= mtep_pkg::MS_PER_TICK_RESET;
         mul_valid_ff   <= 1'b0;
         prod_valid_ff  <= 1'b0;
         track_time_ff  <= '0;
      end else begin
         phase_ff      <= phase_in;
         delta_acc_ff  <= delta_acc_in;
         skip_ff       <= skip_in;
         status_ff     <= status_in;
         first_ff      <= first_in;
         if (csr_wr_en) begin
            ms_per_tick_ff <= csr_wr_data;
         end
         // a new track drops any tick scaling still in flight
         mul_valid_ff  <= mul_go;
         prod_valid_ff <= mul_valid_ff && !kill;
         if (kill) begin
            track_time_ff <= '0;
         end else if (prod_valid_ff) begin
            track_time_ff <= track_time_ff + prod_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_go) begin
         mul_a_ff <= acc_shift;
      end
      prod_ff <= product[47:16];
   end

endmodule

// ----- sv/mtep_queue.sv -----
// -----------------------------------------------------------------------------
// mtep_queue
// small event queue between the byte parser and the result sequencer
// -----------------------------------------------------------------------------
module mtep_queue #(
   parameter int unsigned DEPTH = mtep_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mtep_pkg::event_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output mtep_pkg::event_type head
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   mtep_pkg::event_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/mtep_back.sv -----
// -----------------------------------------------------------------------------
// mtep_back
// result sequencer: wait result when time moved, then key on or key off
// -----------------------------------------------------------------------------
module mtep_back #(
   parameter int unsigned SAMPLE_RATE_HZ   = mtep_pkg::SAMPLE_RATE_HZ_DEF,
   parameter int unsigned OSCILLATOR_COUNT = mtep_pkg::OSCILLATOR_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 ev_valid,
   input  mtep_pkg::event_type  ev,
   output logic                 ev_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [3:0]           rsp_channel,
   output mtep_pkg::opcode_type rsp_opcode,
   output logic [31:0]          rsp_operand,
   output logic                 rsp_channel_error,
   output logic                 rsp_last
);

   localparam logic [63:0] DEN = 64'(SAMPLE_RATE_HZ) * 64'd512;

   logic [31:0] phase_rom [128];

   // phase increment per note, built at elaboration from the sample rate
   for (genvar n = 0; n < 128; n++) begin : g_rom
      localparam int unsigned M    = n + 3;
      localparam int unsigned OCT  = M / 12;
      localparam int unsigned SEMI = M % 12;
      localparam logic [63:0] NUM  =
         (64'd55 * 64'(mtep_pkg::SEMITONE_Q31[SEMI])) << OCT;
      localparam logic [63:0] PH   = (NUM + DEN / 2) / DEN;
      assign phase_rom[n] = PH[31:0];
   end

   logic                 cur_valid_ff;
   mtep_pkg::event_type  cur_ff;
   logic [31:0]          last_time_ff;
   logic                 can_load, need_wait, emit, key_done, chan_err;
   logic                 rsp_valid_ff;
   logic [3:0]           rsp_channel_ff;
   mtep_pkg::opcode_type rsp_opcode_ff;
   logic [31:0]          rsp_operand_ff;
   logic                 rsp_channel_error_ff;
   logic                 rsp_last_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel       = rsp_channel_ff;
   assign rsp_opcode        = rsp_opcode_ff;
   assign rsp_operand       = rsp_operand_ff;
   assign rsp_channel_error = rsp_channel_error_ff;
   assign rsp_last          = rsp_last_ff;

   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign need_wait = (cur_ff.time_ms != last_time_ff);
   assign emit      = cur_valid_ff && can_load;
   assign key_done  = emit && !need_wait;
   assign ev_pop    = ev_valid && (!cur_valid_ff || key_done);
   assign chan_err  = ({1'b0, cur_ff.channel} >= 5'(OSCILLATOR_COUNT));

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         last_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ev_pop) begin
            cur_valid_ff <= 1'b1;
         end else if (key_done) begin
            cur_valid_ff <= 1'b0;
         end
         if (emit && need_wait) begin
            last_time_ff <= cur_ff.time_ms;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ev_pop) begin
         cur_ff <= ev;
      end
      if (emit) begin
         rsp_channel_ff       <= cur_ff.channel;
         rsp_channel_error_ff <= chan_err;
         if (need_wait) begin
            rsp_opcode_ff  <= mtep_pkg::OP_WAIT;
            rsp_operand_ff <= cur_ff.time_ms - last_time_ff;
            rsp_last_ff    <= 1'b0;
         end else if (cur_ff.key_on) begin
            rsp_opcode_ff  <= mtep_pkg::OP_KEY_ON;
            rsp_operand_ff <= phase_rom[cur_ff.note];
            rsp_last_ff    <= 1'b1;
         end else begin
            rsp_opcode_ff  <= mtep_pkg::OP_KEY_OFF;
            rsp_operand_ff <= '0;
            rsp_last_ff    <= 1'b1;
         end
      end
   end

endmodule

// ----- sv/midi_track_event_parser_top.sv -----
// -----------------------------------------------------------------------------
// midi_track_event_parser_top
// Takes one track-chunk byte per cycle. Each byte is parsed combinationally, so
// req_tready stays high as long as the event queue (QUEUE_DEPTH entries) has
// room; it falls only when results back up on the rsp side. Delta times are
// scaled through a two-stage multiply and add that finishes before the
// earliest following note can use the track time. A note on or note off event
// gives one or two results, one per cycle unless rsp stalls, from the sequencer
// behind the queue, so a note event (at least three bytes) never limits the
// byte rate. The phase increment table is built at elaboration from SAMPLE_RATE_HZ.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module midi_track_event_parser_top #(
   parameter int unsigned SAMPLE_RATE_HZ   = mtep_pkg::SAMPLE_RATE_HZ_DEF,
   parameter int unsigned OSCILLATOR_COUNT = mtep_pkg::OSCILLATOR_COUNT_DEF,
   parameter int unsigned QUEUE_DEPTH      = mtep_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [mtep_pkg::MS_PER_TICK_W-1:0] csr_wr_data,   // ms_per_tick
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,     // data_byte
   input  logic                               req_tuser,     // track_start
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [39:0]                        rsp_tdata,     // channel, operand, zero pad
   output logic [2:0]                         rsp_tuser,     // opcode, channel_error
   output logic                               rsp_tlast
);

   logic                 byte_valid;
   logic                 q_push, q_pop, q_full, q_not_empty;
   mtep_pkg::event_type  q_in, q_head;
   logic [3:0]           out_channel;
   mtep_pkg::opcode_type out_opcode;
   logic [31:0]          out_operand;
   logic                 out_channel_error;
   logic                 is_wait, wait_taken;

   assign req_tready = !q_full;
   assign byte_valid = req_tvalid && req_tready;

   mtep_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .byte_valid  (byte_valid),
      .data_byte   (req_tdata),
      .track_start (req_tuser),
      .push_valid  (q_push),
      .push_event  (q_in)
   );

   mtep_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   mtep_back #(
      .SAMPLE_RATE_HZ   (SAMPLE_RATE_HZ),
      .OSCILLATOR_COUNT (OSCILLATOR_COUNT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .ev_valid          (q_not_empty),
      .ev                (q_head),
      .ev_pop            (q_pop),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_channel       (out_channel),
      .rsp_opcode        (out_opcode),
      .rsp_operand       (out_operand),
      .rsp_channel_error (out_channel_error),
      .rsp_last          (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, out_operand, out_channel};
   assign rsp_tuser = {out_channel_error, out_opcode};

   assign is_wait    = (out_opcode == mtep_pkg::OP_WAIT);
   assign wait_taken = rsp_tvalid && rsp_tready && is_wait;

   // a wait result is never the final one of its event
   `ASSERT_IMPLIES(a_wait_not_last, clock, reset, rsp_tvalid && is_wait, !rsp_tlast)

   // a taken wait beat is directly followed by its key beat
   `ASSERT_NEXT(a_wait_then_key, clock, reset, wait_taken, rsp_tvalid && !is_wait)

   // the parser never pushes into a full queue
   `ASSERT_NEVER(a_no_queue_overflow, clock, reset, q_push && q_full)

endmodule

// ----- test/midi_track_event_parser_top_test.sv -----
// -----------------------------------------------------------------------------
// midi_track_event_parser_top_test
// Self-checking bench for the track event parser. Builds track-chunk byte
// streams (note events, other channel messages, sysex and meta blocks, stray
// bytes and cut-off tracks), predicts the wait / key-on / key-off results
// byte by byte and compares every rsp beat in order, under random gaps on both
// sides, a long rsp hold-off and several ms_per_tick settings.
// -----------------------------------------------------------------------------
module midi_track_event_parser_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned AUDIO_RATE_HZ = 44100;
   localparam int unsigned OSC_COUNT     = 4;

   localparam logic [25:0] MS_MAX        = 26'h3FF_FFFF;
   localparam logic [3:0]  HI_POLY_PRESS = 4'hA;
   localparam logic [3:0]  HI_CONTROL    = 4'hB;
   localparam logic [7:0]  STATUS_SONG   = 8'hF3;
   localparam logic [7:0]  STATUS_RESET  = 8'hFE;
   localparam logic [7:0]  META_TEMPO    = 8'h51;
   localparam logic [7:0]  META_EOT      = 8'h2F;
   localparam logic [7:0]  META_TEXT     = 8'h01;

   // 2^(s/12) in U1.31
   localparam logic [31:0] SEMI_STEP_Q31 [12] = '{
      32'd2147483648, 32'd2275179671, 32'd2410468894, 32'd2553802834,
      32'd2705659852, 32'd2866546760, 32'd3037000500, 32'd3217589947,
      32'd3408917802, 32'd3611622603, 32'd3826380858, 32'd4053909304
   };

   typedef enum logic [2:0] {
      AT_DELTA, AT_STATUS, AT_DATA1, AT_DATA2, AT_LENGTH, AT_META_TYPE, AT_SKIP
   } parse_step_type;

   typedef struct {
      logic [3:0]           channel;
      mtep_pkg::opcode_type opcode;
      logic [31:0]          operand;
      logic                 chan_err;
      logic                 last;
   } note_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [25:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;     // data_byte
   logic        req_tuser = 1'b0;   // track_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // channel, operand, zero pad
   logic [2:0]  rsp_tuser;          // opcode, channel_error
   logic        rsp_tlast;

   // parser state as predicted
   logic [25:0]     tick_scale = mtep_pkg::MS_PER_TICK_RESET;
   parse_step_type  parse_at = AT_DELTA;
   logic [31:0]     delta_ticks = '0;
   logic [31:0]     track_ms = '0;
   logic [31:0]     last_wait_ms = '0;
   logic [7:0]      held_status = '0;
   logic [7:0]      held_note = '0;
   logic [31:0]     skip_left = '0;

   note_result_type results_due[$];
   logic [8:0]   track_bytes[$];    // {track_start, data_byte}
   logic         start_pending = 1'b0;
   int unsigned  mismatches = 0;
   int unsigned  bytes_sent = 0;
   int unsigned  hold_cycles = 0;
   logic         tx_pace = 1'b1;
   logic         rx_pace = 1'b1;

   midi_track_event_parser_top #(
      .SAMPLE_RATE_HZ   (AUDIO_RATE_HZ),
      .OSCILLATOR_COUNT (OSC_COUNT)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] key_phase_step(input logic [6:0] note);
      logic [7:0]  m;
      logic [63:0] num;
      logic [63:0] den;
      m = {1'b0, note} + 8'd3;
      den = 64'(AUDIO_RATE_HZ) * 64'd512;
      num = (64'd55 * {32'd0, SEMI_STEP_Q31[m % 12]}) << (m / 12);
      return 32'((num + den / 2) / den);
   endfunction

   function automatic void queue_result(input logic [3:0] ch,
                                        input mtep_pkg::opcode_type op,
                                        input logic [31:0] val, input logic fin);
      note_result_type r;
      r.channel  = ch;
      r.opcode   = op;
      r.operand  = val;
      r.chan_err = (ch >= OSC_COUNT);
      r.last     = fin;
      results_due.push_back(r);
   endfunction

   function automatic void parse_track_byte(input logic [7:0] b, input logic start);
      logic [63:0] scaled;
      logic [3:0]  hi;
      hi = held_status[7:4];
      if (start) begin
         track_ms    = '0;
         parse_at    = AT_DELTA;
         delta_ticks = '0;
         skip_left   = '0;
      end
      case (parse_at)
         AT_STATUS: begin
            held_status = b;
            if (b == mtep_pkg::STATUS_SYSEX) begin
               skip_left = '0;
               parse_at  = AT_LENGTH;
            end else if (b == mtep_pkg::STATUS_META) begin
               parse_at = AT_META_TYPE;
            end else if (b[7] && b[7:4] <= mtep_pkg::HI_PITCH_BEND) begin
               parse_at = AT_DATA1;
            end else begin
               parse_at = AT_DELTA;
            end
         end
         AT_DATA1: begin
            held_note = b;
            parse_at  = (hi == mtep_pkg::HI_PROGRAM || hi == mtep_pkg::HI_CHAN_PRESS) ?
                        AT_DELTA : AT_DATA2;
         end
         AT_DATA2: begin
            parse_at = AT_DELTA;
            if (hi == mtep_pkg::HI_NOTE_OFF || hi == mtep_pkg::HI_NOTE_ON) begin
               if (last_wait_ms != track_ms) begin
                  queue_result(held_status[3:0], mtep_pkg::OP_WAIT,
                               track_ms - last_wait_ms, 1'b0);
                  last_wait_ms = track_ms;
               end
               if (hi == mtep_pkg::HI_NOTE_ON)
                  queue_result(held_status[3:0], mtep_pkg::OP_KEY_ON,
                               key_phase_step(held_note[6:0]), 1'b1);
               else
                  queue_result(held_status[3:0], mtep_pkg::OP_KEY_OFF, 32'd0, 1'b1);
            end
         end
         AT_META_TYPE: begin
            skip_left = '0;
            parse_at  = AT_LENGTH;
         end
         AT_LENGTH: begin
            skip_left = {skip_left[24:0], b[6:0]};
            if (!b[7])
               parse_at = (skip_left == 0) ? AT_DELTA : AT_SKIP;
         end
         AT_SKIP: begin
            skip_left = skip_left - 1;
            if (skip_left == 0)
               parse_at = AT_DELTA;
         end
         default: begin
            delta_ticks = {delta_ticks[24:0], b[6:0]};
            if (!b[7]) begin
               scaled      = {32'd0, delta_ticks} * {38'd0, tick_scale};
               track_ms    = track_ms + scaled[47:16];
               delta_ticks = '0;
               parse_at    = AT_STATUS;
            end else begin
               parse_at = AT_DELTA;
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------ checker

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 40)
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_results
      note_result_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t ns: unexpected beat, expected none, actual tdata %0h tuser %0h",
                        $time, rsp_tdata, rsp_tuser);
         end else begin
            due = results_due.pop_front();
            check_field("channel", {28'd0, due.channel}, {28'd0, rsp_tdata[3:0]});
            check_field("operand", due.operand, rsp_tdata[35:4]);
            check_field("pad", 32'd0, {28'd0, rsp_tdata[39:36]});
            check_field("opcode", {30'd0, due.opcode}, {30'd0, rsp_tuser[1:0]});
            check_field("channel_error", {31'd0, due.chan_err}, {31'd0, rsp_tuser[2]});
            check_field("last", {31'd0, due.last}, {31'd0, rsp_tlast});
         end
      end
   end

   // rsp side: random stall after each beat, long hold-off on request
   initial begin : rsp_drive
      int unsigned stall;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            rsp_tready <= 1'b1;
         end else if (rsp_tready && rsp_tvalid) begin
            stall = rx_pace ? $urandom_range(0, 9) : 0;
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- req side

   task automatic send_byte(input logic [7:0] b, input logic start);
      int unsigned gap;
      gap = tx_pace ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      parse_track_byte(b, start);
      bytes_sent++;
   endtask

   task automatic flush_bytes();
      logic [8:0] x;
      while (track_bytes.size() != 0) begin
         x = track_bytes.pop_front();
         send_byte(x[7:0], x[8]);
      end
   endtask

   // lower valid and wait until every predicted beat has come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0);
   endtask

   task automatic write_ms_per_tick(input logic [25:0] v);
      drain_results();
      // let a delta still in the multiply pipe settle first
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      tick_scale = v;
   endtask

   task automatic add_byte(input logic [7:0] b);
      track_bytes.push_back({start_pending, b});
      start_pending = 1'b0;
   endtask

   task automatic add_vlq(input logic [27:0] v);
      logic [6:0] grp [4];
      int first;
      grp[0] = v[27:21];
      grp[1] = v[20:14];
      grp[2] = v[13:7];
      grp[3] = v[6:0];
      first = 3;
      for (int i = 2; i >= 0; i--)
         if (v >> (7 * (3 - i)) != 0)
            first = i;
      for (int i = first; i < 4; i++)
         add_byte({i != 3, grp[i]});
   endtask

   task automatic add_channel_msg(input logic [27:0] delta, input logic [7:0] st,
                                  input logic [7:0] d1, input logic [7:0] d2);
      add_vlq(delta);
      add_byte(st);
      add_byte(d1);
      if (st[7:4] != mtep_pkg::HI_PROGRAM && st[7:4] != mtep_pkg::HI_CHAN_PRESS)
         add_byte(d2);
   endtask

   task automatic add_blob(input logic [27:0] delta, input logic is_meta,
                           input logic [7:0] kind, input logic [27:0] len);
      add_vlq(delta);
      if (is_meta) begin
         add_byte(mtep_pkg::STATUS_META);
         add_byte(kind);
      end else begin
         add_byte(mtep_pkg::STATUS_SYSEX);
      end
      add_vlq(len);
      repeat (len) add_byte(8'($urandom_range(0, 255)));
   endtask

   function automatic logic [27:0] rand_delta();
      int unsigned k;
      k = $urandom_range(0, 19);
      if (k < 8)
         return 28'd0;
      if (k < 16)
         return 28'($urandom_range(1, 127));
      if (k < 19)
         return 28'($urandom_range(128, 16383));
      return 28'($urandom_range(16384, 28'hFFF_FFFF));
   endfunction

   task automatic add_random_event();
      int unsigned pick;
      logic [31:0] rnd;
      pick = $urandom_range(0, 99);
      rnd  = $urandom;
      if (pick < 55) begin
         add_channel_msg(rand_delta(),
                         {rnd[24] ? mtep_pkg::HI_NOTE_ON : mtep_pkg::HI_NOTE_OFF, rnd[3:0]},
                         rnd[15:8], rnd[23:16]);
      end else if (pick < 68) begin
         add_channel_msg(rand_delta(),
                         {4'($urandom_range(HI_POLY_PRESS, mtep_pkg::HI_PITCH_BEND)),
                          rnd[3:0]}, rnd[15:8], rnd[23:16]);
      end else if (pick < 78) begin
         add_blob(rand_delta(), rnd[24], rnd[15:8],
                  (rnd[31:28] == 0) ? 28'($urandom_range(128, 300))
                                    : 28'($urandom_range(0, 6)));
      end else if (pick < 88) begin
         add_byte(rnd[7:0]);
      end else if (pick < 93) begin
         start_pending = 1'b1;
      end else if (pick < 97) begin
         // runaway length field, cut off by a new track
         add_vlq(rand_delta());
         add_byte(mtep_pkg::STATUS_SYSEX);
         repeat ($urandom_range(2, 5)) add_byte(8'($urandom_range(8'h80, 8'hFF)));
         add_byte(8'($urandom_range(0, 8'h7F)));
         repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
         start_pending = 1'b1;
      end else begin
         // overlong delta wraps the tick count
         repeat ($urandom_range(5, 7)) add_byte(8'($urandom_range(8'h80, 8'hFF)));
         add_byte(8'($urandom_range(0, 8'h7F)));
         add_byte({mtep_pkg::HI_NOTE_ON, rnd[3:0]});
         add_byte(rnd[15:8]);
         add_byte(rnd[23:16]);
      end
   endtask

   // ------------------------------------------------------------------- tests

   task automatic test_note_events();
      start_pending = 1'b1;
      // same time as the last wait: key on only, velocity 0 still keys on
      add_channel_msg(28'd0, {mtep_pkg::HI_NOTE_ON, 4'h0}, 8'h00, 8'h00);
      // bit 7 of the note byte is dropped, channel 15 is flagged
      add_channel_msg(28'd96, {mtep_pkg::HI_NOTE_ON, 4'hF}, 8'hFF, 8'h7F);
      add_channel_msg(28'd128, {mtep_pkg::HI_NOTE_OFF, 4'h3}, 8'h40, 8'h40);
      add_channel_msg(28'd0, {mtep_pkg::HI_NOTE_OFF, 4'h4}, 8'h7F, 8'h00);
      flush_bytes();
      drain_results();
   endtask

   task automatic test_other_messages();
      add_channel_msg(28'd5, {HI_POLY_PRESS, 4'h2}, 8'h01, 8'h02);
      add_channel_msg(28'd6, {HI_CONTROL, 4'h5}, 8'h07, 8'h64);
      add_channel_msg(28'd7, {mtep_pkg::HI_PROGRAM, 4'h7}, 8'h10, 8'h00);
      add_channel_msg(28'd8, {mtep_pkg::HI_CHAN_PRESS, 4'h8}, 8'h20, 8'h00);
      add_channel_msg(28'd9, {mtep_pkg::HI_PITCH_BEND, 4'hF}, 8'h00, 8'h40);
      // data byte where a status belongs: dropped, next byte is a delta
      add_vlq(28'd1);
      add_byte(8'h40);
      add_vlq(28'd2);
      add_byte(STATUS_SONG);
      add_vlq(28'd3);
      add_byte(STATUS_RESET);
      add_channel_msg(28'd0, {mtep_pkg::HI_NOTE_ON, 4'h1}, 8'h3C, 8'h64);
      flush_bytes();
      drain_results();
   endtask

   task automatic test_sysex_meta();
      add_blob(28'd1, 1'b0, 8'h00, 28'd0);
      add_blob(28'd2, 1'b0, 8'h00, 28'd3);
      add_blob(28'd3, 1'b1, META_TEMPO, 28'd3);
      add_blob(28'd4, 1'b1, META_EOT, 28'd0);
      add_blob(28'd5, 1'b0, 8'h00, 28'd128);
      // padded sysex length: continuation byte with empty payload bits
      add_vlq(28'd6);
      add_byte(mtep_pkg::STATUS_SYSEX);
      add_byte(8'h80);
      add_byte(8'h02);
      add_byte(8'h11);
      add_byte(8'h22);
      add_channel_msg(28'd1, {mtep_pkg::HI_NOTE_ON, 4'h2}, 8'h45, 8'h10);
      // huge meta length, then a new track restarts time below the last wait
      add_vlq(28'd0);
      add_byte(mtep_pkg::STATUS_META);
      add_byte(META_TEXT);
      add_byte(8'h8F);
      add_byte(8'hFF);
      add_byte(8'hFF);
      add_byte(8'h7F);
      repeat (3) add_byte(8'h11);
      start_pending = 1'b1;
      add_channel_msg(28'd0, {mtep_pkg::HI_NOTE_ON, 4'h2}, 8'h45, 8'h10);
      flush_bytes();
      drain_results();
   endtask

   task automatic test_delta_scale();
      write_ms_per_tick(MS_MAX);
      start_pending = 1'b1;
      add_channel_msg(28'hFFF_FFFF, {mtep_pkg::HI_NOTE_ON, 4'h1}, 8'h45, 8'h01);
      // more than four delta bytes: tick count wraps
      repeat (5) add_byte(8'hFF);
      add_byte(8'h7F);
      add_byte({mtep_pkg::HI_NOTE_OFF, 4'h1});
      add_byte(8'h45);
      add_byte(8'h00);
      flush_bytes();
      write_ms_per_tick(26'd0);
      add_channel_msg(28'd100, {mtep_pkg::HI_NOTE_ON, 4'h0}, 8'h30, 8'h40);
      flush_bytes();
      write_ms_per_tick(26'h001_8000);
      add_channel_msg(28'd3, {mtep_pkg::HI_NOTE_OFF, 4'h0}, 8'h30, 8'h40);
      flush_bytes();
      drain_results();
   endtask

   task automatic test_backpressure();
      logic [31:0] rnd;
      hold_cycles = 300;
      repeat (12) begin
         rnd = $urandom;
         add_channel_msg(28'd1,
                         {rnd[4] ? mtep_pkg::HI_NOTE_ON : mtep_pkg::HI_NOTE_OFF, rnd[3:0]},
                         rnd[15:8], rnd[23:16]);
      end
      flush_bytes();
      drain_results();
   endtask

   task automatic test_random(input int unsigned total);
      int unsigned stop_at;
      for (int chunk = 0; chunk < 6; chunk++) begin
         case (chunk)
            0, 3, 5: write_ms_per_tick(26'($urandom_range(1, 26'h003_FFFF)));
            1:       write_ms_per_tick(26'($urandom_range(0, MS_MAX)));
            2:       write_ms_per_tick(mtep_pkg::MS_PER_TICK_RESET);
            default: write_ms_per_tick(MS_MAX);
         endcase
         tx_pace = ($urandom_range(0, 3) != 0);
         rx_pace = ($urandom_range(0, 3) != 0);
         start_pending = 1'b1;
         stop_at = bytes_sent + total / 6;
         while (bytes_sent < stop_at) begin
            add_random_event();
            flush_bytes();
            if ($urandom_range(0, 49) == 0)
               drain_results();
         end
      end
      tx_pace = 1'b1;
      rx_pace = 1'b1;
      drain_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_note_events();
      test_other_messages();
      test_sysex_meta();
      test_delta_scale();
      test_backpressure();
      test_random(900);
      drain_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("PASS midi_track_event_parser_top");
      else
         $display("FAIL midi_track_event_parser_top");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL midi_track_event_parser_top");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/mtep_pkg.sv
sv/mtep_front.sv
sv/mtep_queue.sv
sv/mtep_back.sv
sv/midi_track_event_parser_top.sv
test/midi_track_event_parser_top_test.sv
